FILE: hdl/iirdf1_pkg.sv
// ============================================================================
// iirdf1_pkg - shared types and constants of the direct form one IIR filter
// Configuration register map, coefficient format and the bundle of register
// values passed from the register file to the datapath.
// ============================================================================
package iirdf1_pkg;

    // coefficient format: signed Q3.14 in 18 bits, three feed/back pairs
    localparam int COEF_BITS      = 18;
    localparam int COEF_PAIRS     = 3;
    localparam int TAP_COUNT_BITS = 2;
    localparam int CFG_IDX_BITS   = 3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEED_ZERO  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEED_ONE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEED_TWO   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BACK_ZERO  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BACK_ONE   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_BACK_TWO   = 3'd6;

    // reset values: three taps, unity gain on the current sample
    localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 2'd3;
    localparam logic [COEF_BITS-1:0]      FEED_ZERO_RESET = 18'sd16384;

    typedef logic signed [COEF_BITS-1:0] t_coef;

    typedef struct packed {
        logic [TAP_COUNT_BITS-1:0] tap_count;
        t_coef [COEF_PAIRS-1:0]    feed;
        t_coef [COEF_PAIRS-1:0]    back;
    } t_cfg;

endpackage

FILE: hdl/iir_direct_form_one_filter.sv
// Path: an accepted sample is held in the input register, then moves into the
//   result register once the output is free.
// Throughput: one sample per cycle unless the output stalls; y[n-1] feeds back
//   through the six parallel multipliers and the rounding/saturation adder.
// Reset (synchronous, active low): delay lines cleared, three taps, unity gain.
// ============================================================================
// iir_direct_form_one_filter - fixed point direct form one IIR filter
// Input register, combinational MAC datapath with delay lines, and an output
// register that lets a new sample enter while a result waits.
// ============================================================================
module iir_direct_form_one_filter #(
    parameter int MAX_TAPS       = 3,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [iirdf1_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [iirdf1_pkg::COEF_BITS-1:0]    i_cfg_data,
    // sample input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    // sample output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out,
    output logic                                o_clipped
);
    import iirdf1_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    t_cfg                          cfg;
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_clipped;
    logic signed [SAMPLE_BITS-1:0] dp_sample;
    logic                          dp_clipped;
    logic                          advance;
    logic                          in_take;

    iirdf1_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    iirdf1_datapath #(
        .MAX_TAPS       (MAX_TAPS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_sample  (r_in_sample),
        .i_advance (advance),
        .o_sample  (dp_sample),
        .o_clipped (dp_clipped)
    );

    // move the held sample into the result register when that is free or drains
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_take     = i_in_valid && o_in_ready;

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clipped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample <= i_sample_in;
        end
        if (advance) begin
            r_out_sample  <= dp_sample;
            r_out_clipped <= dp_clipped;
        end
    end

    // a full input stage behind a stalled result must block new transactions
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both stages are stalled");

    // every advance produces a visible result in the next cycle
    a_advance_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced sample did not reach the output register");

    // an accepted sample is held in the input stage on the next cycle
    a_take_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted sample lost from the input stage");

    // saturation only ever yields a full-scale value
    a_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_sample_out == SAMPLE_MAX || o_sample_out == SAMPLE_MIN))
        else $error("clipped flag set on a value that is not full scale");

    // reset leaves both stages empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");

endmodule

FILE: hdl/iirdf1_cfg.sv
// ============================================================================
// iirdf1_cfg - configuration register file
// Holds the tap count and the six coefficients; writes to unused indexes
// are dropped. The write channel is always ready.
// ============================================================================
module iirdf1_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [iirdf1_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [iirdf1_pkg::COEF_BITS-1:0]    i_cfg_data,
    output iirdf1_pkg::t_cfg                    o_cfg
);
    import iirdf1_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TAP_COUNT: n_cfg.tap_count = i_cfg_data[TAP_COUNT_BITS-1:0];
                REG_FEED_ZERO: n_cfg.feed[0]   = i_cfg_data;
                REG_FEED_ONE:  n_cfg.feed[1]   = i_cfg_data;
                REG_FEED_TWO:  n_cfg.feed[2]   = i_cfg_data;
                REG_BACK_ZERO: n_cfg.back[0]   = i_cfg_data;
                REG_BACK_ONE:  n_cfg.back[1]   = i_cfg_data;
                REG_BACK_TWO:  n_cfg.back[2]   = i_cfg_data;
                default:       n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg           <= '0;
            r_cfg.tap_count <= TAP_COUNT_RESET;
            r_cfg.feed[0]   <= FEED_ZERO_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: hdl/iirdf1_datapath.sv
// ============================================================================
// iirdf1_datapath - multiply-accumulate, rounding, saturation and history
// Computes one output sample from the registered input sample and the two
// delay lines; the delay lines shift when the result is taken into the
// output register.
// ============================================================================
module iirdf1_datapath #(
    parameter int MAX_TAPS       = 3,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iirdf1_pkg::t_cfg              i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_advance,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_clipped
);
    import iirdf1_pkg::*;

    localparam int USE_TAPS  = (MAX_TAPS < COEF_PAIRS) ? MAX_TAPS : COEF_PAIRS;
    localparam int HIST_IN   = (USE_TAPS > 1) ? USE_TAPS - 1 : 1;
    localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
    localparam int WIDE_FRAC = (COEF_FRAC_BITS > COEF_BITS) ? COEF_FRAC_BITS : COEF_BITS;
    localparam int ACC_W     = SAMPLE_BITS + WIDE_FRAC + 4;
    localparam int HI_W      = ACC_W - COEF_FRAC_BITS - SAMPLE_BITS + 1;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0]  SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0]  SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_past_in  [HIST_IN];
    logic signed [SAMPLE_BITS-1:0] r_past_out [USE_TAPS];

    logic signed [PROD_W-1:0] prod_feed [USE_TAPS];
    logic signed [PROD_W-1:0] prod_back [USE_TAPS];
    logic [USE_TAPS-1:0]      tap_on;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic [HI_W-1:0]          acc_hi;

    // one product pair per tap, all in parallel
    genvar gi;
    generate
        for (gi = 0; gi < USE_TAPS; gi++) begin : g_tap
            logic signed [SAMPLE_BITS-1:0] x_tap;
            t_coef                         c_feed;
            t_coef                         c_back;
            if (gi == 0) begin : g_cur
                assign x_tap = i_sample;
            end else begin : g_hist
                assign x_tap = r_past_in[gi-1];
            end
            assign c_feed        = i_cfg.feed[gi];
            assign c_back        = i_cfg.back[gi];
            assign prod_feed[gi] = c_feed * x_tap;
            assign prod_back[gi] = c_back * r_past_out[gi];
            // a tap count of zero still runs the first tap
            assign tap_on[gi]    = (gi == 0) ||
                                   (i_cfg.tap_count > TAP_COUNT_BITS'(gi));
        end
    endgenerate

    always_comb begin
        acc = '0;
        for (int k = 0; k < USE_TAPS; k++) begin
            if (tap_on[k]) begin
                acc = acc + ACC_W'(prod_feed[k]) + ACC_W'(prod_back[k]);
            end
        end
        acc_rnd = acc + HALF_LSB;
        acc_hi  = acc_rnd[ACC_W-1 -: HI_W];
    end

    // all bits above the result's sign must agree, else saturate
    assign o_clipped = (|acc_hi) && !(&acc_hi);
    assign o_sample  = o_clipped
                     ? (acc_rnd[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                     : acc_rnd[COEF_FRAC_BITS +: SAMPLE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_IN; k++) begin
                r_past_in[k] <= '0;
            end
            for (int k = 0; k < USE_TAPS; k++) begin
                r_past_out[k] <= '0;
            end
        end else if (i_advance) begin
            for (int k = HIST_IN - 1; k > 0; k--) begin
                r_past_in[k] <= r_past_in[k-1];
            end
            r_past_in[0] <= i_sample;
            for (int k = USE_TAPS - 1; k > 0; k--) begin
                r_past_out[k] <= r_past_out[k-1];
            end
            r_past_out[0] <= o_sample;
        end
    end

endmodule

FILE: test/tb_iir_direct_form_one_filter.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_iir_direct_form_one_filter - self-checking bench of the direct form one IIR
// Runs a directed table of register writes and samples, then random
// coefficient sets with random sample streams under varying backpressure.
// Each output is compared with its table value or with a bit-exact predictor.
// ============================================================================
module tb_iir_direct_form_one_filter;
    import iirdf1_pkg::*;

    localparam int SAMPLE_W        = 16;
    localparam int FRAC_BITS       = 14;
    localparam int HIST_TAPS       = 3;
    localparam int SAMPLE_MAX      = 32767;
    localparam int SAMPLE_MIN      = -32768;
    localparam int COEF_MAX        = 131071;
    localparam int COEF_MIN        = -131072;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SEGMENTS        = 4;
    localparam int SEG_ITEMS       = 67;
    localparam int MAX_REPORTS     = 10;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

    typedef enum logic { ROW_CONFIG, ROW_SAMPLE } t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [CFG_IDX_BITS-1:0]     idx;
        logic [COEF_BITS-1:0]        data;
        logic signed [SAMPLE_W-1:0]  sample;
        bit                          typed;
        logic signed [SAMPLE_W-1:0]  y;
        logic                        clip;
    } t_stim_row;

    typedef struct {
        logic signed [SAMPLE_W-1:0] y;
        logic                       clip;
    } t_filtered;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]     i_cfg_index;
    logic [COEF_BITS-1:0]        i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic signed [SAMPLE_W-1:0]  i_sample_in;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [SAMPLE_W-1:0]  o_sample_out;
    logic                        o_clipped;

    // predictor copy of the register file and delay lines
    logic [TAP_COUNT_BITS-1:0]   pred_taps;
    t_coef                       pred_feed [COEF_PAIRS];
    t_coef                       pred_back [COEF_PAIRS];
    logic signed [SAMPLE_W-1:0]  pred_hist_x [HIST_TAPS-1];
    logic signed [SAMPLE_W-1:0]  pred_hist_y [HIST_TAPS];

    t_filtered                   pending_outputs [$];
    t_stim_row                   stim_rows [$];
    int                          mismatch_count;
    int                          cycle_count;
    int                          sender_idle_pct;
    int                          receiver_idle_pct;
    bit                          hold_off_request;

    iir_direct_form_one_filter #(
        .MAX_TAPS       (HIST_TAPS),
        .SAMPLE_BITS    (SAMPLE_W),
        .COEF_FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    task automatic apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [COEF_BITS-1:0] data);
        case (idx)
            REG_TAP_COUNT: pred_taps    = data[TAP_COUNT_BITS-1:0];
            REG_FEED_ZERO: pred_feed[0] = data;
            REG_FEED_ONE:  pred_feed[1] = data;
            REG_FEED_TWO:  pred_feed[2] = data;
            REG_BACK_ZERO: pred_back[0] = data;
            REG_BACK_ONE:  pred_back[1] = data;
            REG_BACK_TWO:  pred_back[2] = data;
            default: ;  // unmapped index: drop the write
        endcase
    endtask

    task automatic filter_sample(input logic signed [SAMPLE_W-1:0] x,
                                 output t_filtered res);
        logic signed [SAMPLE_W-1:0] line_x [HIST_TAPS];
        longint acc;
        longint q;
        int     n;
        n = (pred_taps == 0) ? 1 : int'(pred_taps);
        line_x[0] = x;
        line_x[1] = pred_hist_x[0];
        line_x[2] = pred_hist_x[1];
        acc = 0;
        for (int i = 0; i < HIST_TAPS; i++) begin
            if (i < n) begin
                acc += longint'(pred_feed[i]) * longint'(line_x[i]);
                acc += longint'(pred_back[i]) * longint'(pred_hist_y[i]);
            end
        end
        // round half up, then floor shift
        acc += longint'(1) << (FRAC_BITS - 1);
        q = acc >>> FRAC_BITS;
        res.clip = 1'b0;
        if (q > SAMPLE_MAX) begin
            q        = SAMPLE_MAX;
            res.clip = 1'b1;
        end else if (q < SAMPLE_MIN) begin
            q        = SAMPLE_MIN;
            res.clip = 1'b1;
        end
        res.y = q[SAMPLE_W-1:0];
        pred_hist_x[1] = pred_hist_x[0];
        pred_hist_x[0] = x;
        pred_hist_y[2] = pred_hist_y[1];
        pred_hist_y[1] = pred_hist_y[0];
        pred_hist_y[0] = res.y;
    endtask

    // ------------------------------------------------------------------
    // drivers; every task is entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COEF_BITS-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input bit typed,
                               input logic signed [SAMPLE_W-1:0] y, input logic clip);
        t_filtered res;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_sample_in = x;
        do @(posedge i_clk); while (!o_in_ready);
        filter_sample(x, res);
        if (typed) begin
            res.y    = y;
            res.clip = clip;
        end
        pending_outputs.push_back(res);
        @(negedge i_clk);
    endtask

    // hold the input low until every result is out, then let the pipe settle
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending_outputs.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic logic [COEF_BITS-1:0] rand_coef(input bit feedback);
        int pick;
        int v;
        pick = $urandom_range(9);
        case (pick)
            0:       v = COEF_MAX;
            1:       v = COEF_MIN;
            2:       v = int'($urandom);
            default: v = feedback ? int'($urandom_range(12000)) - 6000
                                  : int'($urandom_range(40000)) - 20000;
        endcase
        return v[COEF_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int pick;
        int v;
        pick = $urandom_range(9);
        case (pick)
            0:       v = SAMPLE_MAX;
            1:       v = SAMPLE_MIN;
            2, 3:    v = int'($urandom_range(600)) - 300;
            default: v = int'($urandom);
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic randomize_registers();
        cfg_write(REG_TAP_COUNT, COEF_BITS'($urandom_range(3)));
        cfg_write(REG_FEED_ZERO, rand_coef(1'b0));
        cfg_write(REG_FEED_ONE,  rand_coef(1'b0));
        cfg_write(REG_FEED_TWO,  rand_coef(1'b0));
        cfg_write(REG_BACK_ZERO, rand_coef(1'b1));
        cfg_write(REG_BACK_ONE,  rand_coef(1'b1));
        cfg_write(REG_BACK_TWO,  rand_coef(1'b1));
        cfg_write(REG_UNMAPPED,  rand_coef(1'b0));
    endtask

    function automatic void row_cfg(input logic [CFG_IDX_BITS-1:0] idx, input int v);
        t_stim_row r;
        r = '{kind: ROW_CONFIG, idx: idx, data: v[COEF_BITS-1:0], sample: '0,
              typed: 1'b0, y: '0, clip: 1'b0};
        stim_rows.push_back(r);
    endfunction

    function automatic void row_smp(input int x);
        t_stim_row r;
        r = '{kind: ROW_SAMPLE, idx: '0, data: '0, sample: x[SAMPLE_W-1:0],
              typed: 1'b0, y: '0, clip: 1'b0};
        stim_rows.push_back(r);
    endfunction

    function automatic void row_chk(input int x, input int y, input bit clip);
        t_stim_row r;
        r = '{kind: ROW_SAMPLE, idx: '0, data: '0, sample: x[SAMPLE_W-1:0],
              typed: 1'b1, y: y[SAMPLE_W-1:0], clip: clip};
        stim_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                hold_left        = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_filtered exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected output transaction: y=%0d clip=%0b",
                             $realtime, o_sample_out, o_clipped);
            end else begin
                exp_res = pending_outputs.pop_front();
                if (o_sample_out !== exp_res.y || o_clipped !== exp_res.clip) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] mismatch: expected y=%0d clip=%0b, got y=%0d clip=%0b",
                                 $realtime, exp_res.y, exp_res.clip, o_sample_out, o_clipped);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_sample_in       = '0;
        mismatch_count    = 0;
        cycle_count       = 0;
        hold_off_request  = 1'b0;
        sender_idle_pct   = 20;
        receiver_idle_pct = 78;
        pred_taps         = TAP_COUNT_RESET;
        for (int i = 0; i < COEF_PAIRS; i++) begin
            pred_feed[i] = '0;
            pred_back[i] = '0;
        end
        pred_feed[0] = FEED_ZERO_RESET;
        for (int i = 0; i < HIST_TAPS - 1; i++) pred_hist_x[i] = '0;
        for (int i = 0; i < HIST_TAPS; i++) pred_hist_y[i] = '0;

        // reset state is unity gain: samples pass through
        row_chk(0, 0, 1'b0);
        row_chk(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        row_chk(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        row_chk(-1, -1, 1'b0);
        // largest gain saturates both ways
        row_cfg(REG_FEED_ZERO, COEF_MAX);
        row_cfg(REG_TAP_COUNT, 1);
        row_chk(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        row_chk(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        row_chk(0, 0, 1'b0);
        row_cfg(REG_FEED_ZERO, COEF_MIN);
        row_chk(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        row_chk(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        // gain of one half: ties round toward plus infinity
        row_cfg(REG_FEED_ZERO, 8192);
        row_chk(1, 1, 1'b0);
        row_chk(-1, 0, 1'b0);
        row_chk(-3, -1, 1'b0);
        // zero taps acts as one tap, so the second pair stays out
        row_cfg(REG_TAP_COUNT, 0);
        row_cfg(REG_FEED_ZERO, 16384);
        row_cfg(REG_FEED_ONE, COEF_MAX);
        row_cfg(REG_BACK_ONE, COEF_MIN);
        row_chk(1234, 1234, 1'b0);
        row_chk(-5, -5, 1'b0);
        // write to an unmapped index must not land anywhere
        row_cfg(REG_UNMAPPED, COEF_MAX);
        row_chk(77, 77, 1'b0);
        row_cfg(REG_TAP_COUNT, 3);
        row_cfg(REG_FEED_ONE, -8192);
        row_cfg(REG_FEED_TWO, 4096);
        row_cfg(REG_BACK_ZERO, 8192);
        row_cfg(REG_BACK_ONE, -4096);
        row_cfg(REG_BACK_TWO, 2048);
        row_smp(10000);
        row_smp(-20000);
        row_smp(SAMPLE_MAX);
        row_smp(SAMPLE_MIN);
        row_smp(500);
        row_cfg(REG_TAP_COUNT, 2);
        row_smp(12345);
        row_smp(-12345);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_CONFIG) begin
                wait_drained();
                cfg_write(stim_rows[r].idx, stim_rows[r].data);
            end else begin
                send_sample(stim_rows[r].sample, stim_rows[r].typed,
                            stim_rows[r].y, stim_rows[r].clip);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 20;
                    receiver_idle_pct = 78;
                end
                1: begin
                    sender_idle_pct   = 78;
                    receiver_idle_pct = 20;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                wait_drained();
                randomize_registers();
                // stall the output while the sender keeps pushing
                if (phase == 2 && seg == 1) hold_off_request = 1'b1;
                repeat (SEG_ITEMS) send_sample(rand_sample(), 1'b0, '0, 1'b0);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (pending_outputs.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/iirdf1_pkg.sv
hdl/iirdf1_cfg.sv
hdl/iirdf1_datapath.sv
hdl/iir_direct_form_one_filter.sv
test/tb_iir_direct_form_one_filter.sv
